// ===== rtl/core/nguf_pkg.sv =====
// Package for the node grouping union-find block.
// Holds node kind, edge kind and op codes plus the kind update functions.
// No dependencies.
package nguf_pkg;

  localparam int NODE_W = 10;

  typedef logic [2:0] kind_t;
  typedef logic [3:0] rank_t;

  localparam kind_t KIND_UNSEEN     = 3'd0;
  localparam kind_t KIND_NORMAL     = 3'd1;
  localparam kind_t KIND_ENTRY      = 3'd2;
  localparam kind_t KIND_EXIT       = 3'd3;
  localparam kind_t KIND_ENTRY_EXIT = 3'd4;

  localparam logic [1:0] EDGE_CALL  = 2'd0;
  localparam logic [1:0] EDGE_RET   = 2'd1;
  localparam logic [1:0] EDGE_JOIN  = 2'd2;
  localparam logic [1:0] EDGE_OTHER = 2'd3;

  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam rank_t RANK_INIT = 4'd1;
  localparam rank_t RANK_MAX  = 4'd15;

  // Destination side of an edge.
  function automatic kind_t dest_kind(kind_t k, logic [1:0] edge_kind);
    kind_t r;
    r = k;
    if (edge_kind == EDGE_CALL) begin
      case (k) inside
        KIND_UNSEEN, KIND_NORMAL: r = KIND_ENTRY;
        KIND_EXIT:                r = KIND_ENTRY_EXIT;
        default:                  r = k;
      endcase
    end else if (k == KIND_UNSEEN) begin
      r = KIND_NORMAL;
    end
    return r;
  endfunction

  // Source side of an edge.
  function automatic kind_t src_kind(kind_t k, logic [1:0] edge_kind);
    kind_t r;
    r = k;
    if (edge_kind == EDGE_RET) begin
      case (k) inside
        KIND_UNSEEN, KIND_NORMAL: r = KIND_EXIT;
        KIND_ENTRY:               r = KIND_ENTRY_EXIT;
        default:                  r = k;
      endcase
    end else if (k == KIND_UNSEEN) begin
      r = KIND_NORMAL;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/node_group_union_find.sv =====
// Node grouping block: union by rank over a node store, with per-node kind tracking.
// One node memory {kind, rank, parent} with one write and one read port under a small sequencer.
// Depends on nguf_pkg.

// After reset the block runs a clearing pass over all NODE_COUNT entries of the node
// memory before it takes its first item (configuration writes are taken meanwhile).
// Each item then runs alone through the sequencer, and in_tready is high only between
// items. The steps per item: take the item, fold the nodes when NODE_COUNT < 1024,
// make the two kind updates of an enabled edge, walk each root (one link per cycle
// through the memory read port), and hand over the result once the output is free.
// A query walks one root, a dropped or plain edge two, a join edge four plus a union
// write, and a rank update on equal ranks, when the two sets differ. The parent chase
// through the memory read port sets how long an item takes. The result register lets
// the next item be accepted while a result still waits on out_tready.
module node_group_union_find #(
  parameter int NODE_COUNT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [7:0]  cfg_tdata,   // [0] capture_enable
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [9:0] node_a, [19:10] node_b, [21:20] edge_kind
  input  logic        in_tuser,    // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata    // [2:0] node_kind, [12:3] root_of_a, [22:13] root_of_b,
                                   // [23] merged, [24] dropped
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam int WW = AW + 7;
  localparam int NW = nguf_pkg::NODE_W;
  localparam bit FOLD_NEEDED = NODE_COUNT < (1 << NW);
  localparam logic [NW-1:0] NC_N = NW'(NODE_COUNT);
  localparam logic [19:0] FOLD_RECIP = 20'(((1 << 20) + NODE_COUNT - 1) / NODE_COUNT);
  localparam logic [AW-1:0] LAST_NODE = AW'(NODE_COUNT - 1);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_FOLD  = 10'b0000000100,
    S_MRD   = 10'b0000001000,
    S_MWR   = 10'b0000010000,
    S_WRD   = 10'b0000100000,
    S_WALK  = 10'b0001000000,
    S_UNI   = 10'b0010000000,
    S_UNI2  = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic                 cap_en_r;
  logic                 op_r, op_nxt;
  logic [1:0]           ekind_r, ekind_nxt;
  logic [NW-1:0]        fa_r, fa_nxt, fb_r, fb_nxt;
  logic [1:0]           fold_cnt_r, fold_cnt_nxt;
  logic [NW-1:0]        fq_r, fq_nxt;
  logic                 mark_src_r, mark_src_nxt;
  logic                 walk_b_r, walk_b_nxt;
  logic                 join_pass_r, join_pass_nxt;
  logic                 first_r, first_nxt;
  logic [AW-1:0]        cur_r, cur_nxt;
  logic [WW-1:0]        start_w_r, start_w_nxt;
  logic [AW-1:0]        ra_r, ra_nxt, rb_r, rb_nxt;
  logic [WW-1:0]        ra_w_r, ra_w_nxt, rb_w_r, rb_w_nxt;
  nguf_pkg::kind_t      kind_a_r, kind_a_nxt;
  logic                 merged_r, merged_nxt;
  logic                 dropped_r, dropped_nxt;
  logic [AW-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_load;
  logic [31:0]          out_data_r;

  logic [WW-1:0]        mem [NODE_COUNT];
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WW-1:0]        mem_wdata, mem_rdata_r;

  logic [AW-1:0]        na, nb, wnode, rd_parent;
  logic [WW-1:0]        w_start;
  logic [NW-1:0]        fold_src, fold_q, fold_rem;
  logic [NW+19:0]       fold_prod;
  logic [2*NW-1:0]      fold_qn;
  nguf_pkg::kind_t      rd_kind, new_kind;
  nguf_pkg::rank_t      ka, kb, ka_inc;
  logic                 in_fire, in_drop, out_free;

  assign cfg_tready = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_drop    = (in_tuser == nguf_pkg::OP_EDGE) && !cap_en_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  assign na        = AW'(fa_r);
  assign nb        = AW'(fb_r);
  assign wnode     = walk_b_r ? nb : na;
  assign rd_parent = mem_rdata_r[AW-1:0];
  assign rd_kind   = mem_rdata_r[WW-1 -: 3];
  assign w_start   = first_r ? mem_rdata_r : start_w_r;
  // node mod NODE_COUNT by reciprocal multiply: quotient, then remainder, a then b
  assign fold_src  = fold_cnt_r[1] ? fa_r : fb_r;
  assign fold_prod = fold_src * FOLD_RECIP;
  assign fold_q    = fold_prod[NW+19:20];
  assign fold_qn   = fq_r * NC_N;
  assign fold_rem  = fold_src - fold_qn[NW-1:0];
  assign ka        = ra_w_r[AW+3:AW];
  assign kb        = rb_w_r[AW+3:AW];
  assign ka_inc    = (ka == nguf_pkg::RANK_MAX) ? ka : ka + 4'd1;
  assign new_kind  = mark_src_r ? nguf_pkg::src_kind(rd_kind, ekind_r)
                                : nguf_pkg::dest_kind(rd_kind, ekind_r);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    ekind_nxt     = ekind_r;
    fa_nxt        = fa_r;
    fb_nxt        = fb_r;
    fold_cnt_nxt  = fold_cnt_r;
    fq_nxt        = fq_r;
    mark_src_nxt  = mark_src_r;
    walk_b_nxt    = walk_b_r;
    join_pass_nxt = join_pass_r;
    first_nxt     = first_r;
    cur_nxt       = cur_r;
    start_w_nxt   = start_w_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    ra_w_nxt      = ra_w_r;
    rb_w_nxt      = rb_w_r;
    kind_a_nxt    = kind_a_r;
    merged_nxt    = merged_r;
    dropped_nxt   = dropped_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = wnode;
    mem_wdata     = mem_rdata_r;
    mem_raddr     = wnode;

    unique case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = {nguf_pkg::KIND_UNSEEN, nguf_pkg::RANK_INIT, clr_cnt_r};
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_NODE) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          op_nxt        = in_tuser;
          fa_nxt        = in_tdata[9:0];
          fb_nxt        = in_tdata[19:10];
          ekind_nxt     = in_tdata[21:20];
          dropped_nxt   = in_drop;
          merged_nxt    = 1'b0;
          mark_src_nxt  = 1'b0;
          walk_b_nxt    = 1'b0;
          join_pass_nxt = 1'b0;
          fold_cnt_nxt  = 2'd3;
          if (FOLD_NEEDED) begin
            state_nxt = S_FOLD;
          end else if (in_tuser == nguf_pkg::OP_QUERY || in_drop) begin
            state_nxt = S_WRD;
          end else begin
            state_nxt = S_MRD;
          end
        end
      end
      S_FOLD: begin
        fold_cnt_nxt = fold_cnt_r - 2'd1;
        if (fold_cnt_r[0]) begin
          fq_nxt = fold_q;
        end else if (fold_cnt_r[1]) begin
          fa_nxt = fold_rem;
        end else begin
          fb_nxt = fold_rem;
          if (op_r == nguf_pkg::OP_QUERY || dropped_r) begin
            state_nxt = S_WRD;
          end else begin
            state_nxt = S_MRD;
          end
        end
      end
      S_MRD: begin
        mem_raddr = mark_src_r ? na : nb;
        state_nxt = S_MWR;
      end
      S_MWR: begin
        mem_we    = 1'b1;
        mem_waddr = mark_src_r ? na : nb;
        mem_wdata = {new_kind, mem_rdata_r[AW+3:0]};
        if (!mark_src_r) begin
          mark_src_nxt = 1'b1;
          state_nxt    = S_MRD;
        end else begin
          join_pass_nxt = (ekind_r == nguf_pkg::EDGE_JOIN);
          walk_b_nxt    = 1'b0;
          state_nxt     = S_WRD;
        end
      end
      S_WRD: begin
        mem_raddr = wnode;
        cur_nxt   = wnode;
        first_nxt = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        first_nxt = 1'b0;
        if (first_r) begin
          start_w_nxt = mem_rdata_r;
          if (!walk_b_r) kind_a_nxt = rd_kind;
        end
        if (rd_parent == cur_r) begin
          if (!dropped_r) begin
            mem_we    = 1'b1;
            mem_waddr = wnode;
            mem_wdata = {w_start[WW-1:AW], cur_r};
          end
          if (!walk_b_r) begin
            ra_nxt   = cur_r;
            ra_w_nxt = mem_rdata_r;
            if (op_r == nguf_pkg::OP_QUERY) begin
              state_nxt = S_FIN;
            end else begin
              walk_b_nxt = 1'b1;
              state_nxt  = S_WRD;
            end
          end else begin
            rb_nxt   = cur_r;
            rb_w_nxt = mem_rdata_r;
            if (join_pass_r) begin
              if (cur_r == ra_r) begin
                join_pass_nxt = 1'b0;
                walk_b_nxt    = 1'b0;
                state_nxt     = S_WRD;
              end else begin
                state_nxt = S_UNI;
              end
            end else begin
              state_nxt = S_FIN;
            end
          end
        end else begin
          cur_nxt   = rd_parent;
          mem_raddr = rd_parent;
        end
      end
      S_UNI: begin
        merged_nxt    = 1'b1;
        mem_we        = 1'b1;
        join_pass_nxt = 1'b0;
        walk_b_nxt    = 1'b0;
        state_nxt     = S_WRD;
        if (kb > ka) begin
          mem_waddr = ra_r;
          mem_wdata = {ra_w_r[WW-1:AW], rb_r};
        end else begin
          mem_waddr = rb_r;
          mem_wdata = {rb_w_r[WW-1:AW], ra_r};
          if (kb == ka) state_nxt = S_UNI2;
        end
      end
      S_UNI2: begin
        mem_we    = 1'b1;
        mem_waddr = ra_r;
        mem_wdata = {ra_w_r[WW-1 -: 3], ka_inc, ra_w_r[AW-1:0]};
        state_nxt = S_WRD;
      end
      S_FIN: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cap_en_r    <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_tvalid && cfg_tready) cap_en_r <= cfg_tdata[0];
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    ekind_r     <= ekind_nxt;
    fa_r        <= fa_nxt;
    fb_r        <= fb_nxt;
    fold_cnt_r  <= fold_cnt_nxt;
    fq_r        <= fq_nxt;
    mark_src_r  <= mark_src_nxt;
    walk_b_r    <= walk_b_nxt;
    join_pass_r <= join_pass_nxt;
    first_r     <= first_nxt;
    cur_r       <= cur_nxt;
    start_w_r   <= start_w_nxt;
    ra_r        <= ra_nxt;
    rb_r        <= rb_nxt;
    ra_w_r      <= ra_w_nxt;
    rb_w_r      <= rb_w_nxt;
    kind_a_r    <= kind_a_nxt;
    merged_r    <= merged_nxt;
    dropped_r   <= dropped_nxt;
    if (out_load) begin
      out_data_r <= {7'd0, dropped_r, merged_r,
                     (op_r == nguf_pkg::OP_QUERY) ? 10'd0 : 10'(rb_r),
                     10'(ra_r), kind_a_r};
    end
  end

  a_merged_same_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[23] |-> out_data_r[12:3] == out_data_r[22:13])
    else $error("merged result with differing roots");

  a_merged_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[23] && out_data_r[24]))
    else $error("result both merged and dropped");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted without leaving idle");

  a_union_after_walks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UNI |-> join_pass_r && ra_r != rb_r && !dropped_r)
    else $error("union entered outside a join pass");

endmodule
